// File: rtl/core/kbrg_pkg.sv
// Shared types, constants and codes of the key bitmap raster generator.
package kbrg_pkg;

  // Default storage limits, handed to the top-level parameters.
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 64;

  // Widths fixed by the field definitions.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;
  // Counters never exceed 8 bits; comparisons are done one bit wider.
  localparam int CNT_W       = 8;
  localparam int EXT_W       = 9;
  localparam int QUEUE_DEPTH = 2;

  // Frame pattern constants.
  localparam logic [7:0] FRAME_LINE   = 8'hff;
  localparam logic [7:0] FRAME_LINE_L = 8'h7f;
  localparam logic [7:0] FRAME_LINE_R = 8'hfe;
  localparam logic [7:0] FRAME_SIDE_L = 8'h40;
  localparam logic [7:0] FRAME_SIDE_R = 8'h02;
  localparam logic [7:0] FRAME_EMPTY  = 8'h00;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_COLUMNS   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_ROWS      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_KEY    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_PRESENT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_COLUMNS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_ROWS    = 3'd5;

  // How the back end forms the byte of a cell.
  typedef enum logic [2:0] {
    MODE_FRAME     = 3'd0,  // frame only
    MODE_XOR       = 3'd1,  // frame XOR glyph byte
    MODE_CARRY_IN  = 3'd2,  // carried nibble, frame XOR high nibble, store low nibble
    MODE_CARRY_END = 3'd3,  // carried nibble ORed with frame
    MODE_CARRY_OUT = 3'd4   // frame XOR high nibble, store low nibble
  } cell_mode_t;

  // Input word.
  typedef struct packed {
    logic       action;
    logic [7:0] glyph_byte;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [7:0] cell_byte;
    logic [5:0] cell_row;
    logic [5:0] cell_column;
    logic       glyph_taken;
    logic       last_cell;
  } result_t;

  // Classified cell passed from front to back.
  typedef struct packed {
    cell_mode_t       mode;
    logic [7:0]       fill;
    logic [7:0]       glyph;
    logic [CNT_W-1:0] carry_row;
    logic [5:0]       cell_row;
    logic [5:0]       cell_column;
    logic             last_cell;
    logic             invert;
  } cell_cmd_t;

endpackage

// File: rtl/core/kbrg_front.sv
// Front end: configuration registers, cell counters and cell classification.
module kbrg_front import kbrg_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   cmd_valid,
  input  logic                   cmd_ready,
  output cell_cmd_t              cmd
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam logic [EXT_W-1:0] ROWS_MAX = EXT_W'(MAX_ROWS);
  localparam logic [EXT_W-1:0] COLS_MAX = EXT_W'(MAX_COLUMNS);
  localparam logic [EXT_W-1:0] ONE      = EXT_W'(1);
  localparam logic [EXT_W-1:0] TWO      = EXT_W'(2);
  localparam logic [EXT_W-1:0] FOUR     = EXT_W'(4);

  logic [CFG_DATA_W-1:0] key_columns;
  logic [CFG_DATA_W-1:0] key_rows;
  logic                  invert_key;
  logic                  glyph_present;
  logic [CFG_DATA_W-1:0] glyph_columns;
  logic [CFG_DATA_W-1:0] glyph_rows;

  logic [RW-1:0] row_count;
  logic [CW-1:0] column_count;

  logic [EXT_W-1:0] kc_x, kr_x, w, h, gx, gy;
  logic [EXT_W-1:0] l, k;
  logic [EXT_W-1:0] lw, lh, cx, cy, hl, hr, vu, vd;
  logic             glyph_on, odd, rows_in, cols_in, pre_col;
  logic             accept;
  cell_mode_t       mode;

  // Frame pattern of one cell.
  function automatic logic [7:0] frame_byte(input logic [EXT_W-1:0] fl,
                                            input logic [EXT_W-1:0] fk,
                                            input logic [EXT_W-1:0] fw,
                                            input logic [EXT_W-1:0] fh);
    logic       line, edge_row, left, right;
    logic [7:0] f;
    line     = (fk == ONE) || (fk == fh - TWO);
    edge_row = (fk == '0) || (fk == fh - ONE);
    left     = (fl == '0);
    right    = (fl == fw - ONE);
    if (line)              f = FRAME_LINE;
    else if (!left && !right) f = FRAME_EMPTY;
    else                   f = left ? FRAME_SIDE_L : FRAME_SIDE_R;
    if ((left || right) && edge_row) f = FRAME_EMPTY;
    if (line && left)  f = FRAME_LINE_L;
    if (line && right) f = FRAME_LINE_R;
    return f;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_columns   <= CFG_DATA_W'(8);
      key_rows      <= CFG_DATA_W'(16);
      invert_key    <= 1'b0;
      glyph_present <= 1'b0;
      glyph_columns <= '0;
      glyph_rows    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_COLUMNS:   key_columns   <= cfg_data;
        REG_KEY_ROWS:      key_rows      <= cfg_data;
        REG_INVERT_KEY:    invert_key    <= cfg_data[0];
        REG_GLYPH_PRESENT: glyph_present <= cfg_data[0];
        REG_GLYPH_COLUMNS: glyph_columns <= cfg_data;
        REG_GLYPH_ROWS:    glyph_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective key size, clamped to the supported range.
  always_comb begin
    kc_x = EXT_W'(key_columns);
    kr_x = EXT_W'(key_rows);
    gx   = EXT_W'(glyph_columns);
    gy   = EXT_W'(glyph_rows);
    if (kc_x < TWO)           w = TWO;
    else if (kc_x > COLS_MAX) w = COLS_MAX;
    else                      w = kc_x;
    if (kr_x < FOUR)          h = FOUR;
    else if (kr_x > ROWS_MAX) h = ROWS_MAX;
    else                      h = kr_x;
  end

  // Current cell; counters left outside the key restart at the first cell.
  always_comb begin
    if ((EXT_W'(column_count) >= w) || (EXT_W'(row_count) >= h)) begin
      l = '0;
      k = '0;
    end else begin
      l = EXT_W'(column_count);
      k = EXT_W'(row_count);
    end
  end

  // Glyph placement, centered with the spare column or row on the near side.
  always_comb begin
    glyph_on = glyph_present && (gx <= w) && (gy <= h);
    lw       = w - gx;
    lh       = h - gy;
    cx       = lw >> 1;
    cy       = lh >> 1;
    hl       = lw - cx;
    hr       = w - cx;
    vu       = lh - cy;
    vd       = h - cy;
    odd      = lw[0];
    rows_in  = (k >= vu) && (k < vd);
    cols_in  = (l >= hl) && (l < hr);
    pre_col  = odd && (l + ONE == hl) && (l + ONE < hr);
  end

  // Cell classification.
  always_comb begin
    if (glyph_on && rows_in && cols_in) begin
      if (!odd)              mode = MODE_XOR;
      else if (l + ONE < hr) mode = MODE_CARRY_IN;
      else                   mode = MODE_CARRY_END;
    end else if (glyph_on && rows_in && pre_col) begin
      mode = MODE_CARRY_OUT;
    end else begin
      mode = MODE_FRAME;
    end
  end

  assign item_ready = cmd_ready;
  assign accept     = item_valid && item_ready;
  assign cmd_valid  = item_valid && item.action;

  always_comb begin
    cmd.mode        = mode;
    cmd.fill        = frame_byte(l, k, w, h);
    cmd.glyph       = item.glyph_byte;
    cmd.carry_row   = k[CNT_W-1:0];
    cmd.cell_row    = k[5:0];
    cmd.cell_column = l[5:0];
    cmd.last_cell   = (l == w - ONE) && (k == h - ONE);
    cmd.invert      = invert_key;
  end

  // Cell counters, column-major with wrap after the last cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
    end else if (accept) begin
      if (!item.action) begin
        row_count    <= '0;
        column_count <= '0;
      end else if (k + ONE >= h) begin
        row_count    <= '0;
        column_count <= (l + ONE >= w) ? '0 : CW'(l + ONE);
      end else begin
        row_count    <= RW'(k + ONE);
        column_count <= CW'(l);
      end
    end
  end

endmodule

// File: rtl/core/kbrg_queue.sv
// Short queue of classified cells between the front and back ends.
module kbrg_queue import kbrg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  cell_cmd_t wr_cmd,
  output logic      rd_valid,
  input  logic      rd_ready,
  output cell_cmd_t rd_cmd
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [COUNT_W-1:0] FULL      = COUNT_W'(QUEUE_DEPTH);

  cell_cmd_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               push, pop;

  assign wr_ready = (count != FULL);
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + COUNT_W'(1);
      else if (pop && !push) count <= count - COUNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("queue fill level beyond its depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + COUNT_W'(1))
    else $error("queue fill level did not grow on a lone push");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - COUNT_W'(1))
    else $error("queue fill level did not shrink on a lone pop");

endmodule

// File: rtl/core/kbrg_back.sv
// Back end: per-row nibble carry store, byte assembly and result register.
module kbrg_back import kbrg_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cell_cmd_t cmd,
  output logic      result_valid,
  input  logic      result_ready,
  output result_t   result
);

  localparam int RW = $clog2(MAX_ROWS);

  logic [3:0]    nibble_carry [MAX_ROWS];
  logic [3:0]    carry_rd;
  cell_cmd_t     stage;
  logic          stage_valid;
  logic          out_free, pop, load;
  logic [RW-1:0] carry_idx;
  logic [7:0]    carry_hi, glyph_hi, cell_val;

  assign out_free  = !result_valid || result_ready;
  assign cmd_ready = !stage_valid || out_free;
  assign pop       = cmd_valid && cmd_ready;
  assign load      = stage_valid && out_free;
  assign carry_idx = cmd.carry_row[RW-1:0];

  // Carry store: read the old nibble and store the new one as a cell enters.
  always_ff @(posedge clk) begin
    if (pop) begin
      carry_rd <= nibble_carry[carry_idx];
      stage    <= cmd;
      if ((cmd.mode == MODE_CARRY_IN) || (cmd.mode == MODE_CARRY_OUT)) begin
        nibble_carry[carry_idx] <= cmd.glyph[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_ready) begin
      stage_valid <= cmd_valid;
    end
  end

  // Byte assembly from frame, glyph and carried nibble.
  always_comb begin
    carry_hi = {carry_rd, 4'h0};
    glyph_hi = {4'h0, stage.glyph[7:4]};
    unique case (stage.mode)
      MODE_FRAME:     cell_val = stage.fill;
      MODE_XOR:       cell_val = stage.fill ^ stage.glyph;
      MODE_CARRY_IN:  cell_val = carry_hi | (stage.fill ^ glyph_hi);
      MODE_CARRY_END: cell_val = carry_hi | stage.fill;
      MODE_CARRY_OUT: cell_val = stage.fill ^ glyph_hi;
      default:        cell_val = stage.fill;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      result.cell_byte   <= stage.invert ? ~cell_val : cell_val;
      result.cell_row    <= stage.cell_row;
      result.cell_column <= stage.cell_column;
      result.glyph_taken <= (stage.mode == MODE_XOR) || (stage.mode == MODE_CARRY_IN) ||
                            (stage.mode == MODE_CARRY_OUT);
      result.last_cell   <= stage.last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= stage_valid;
    end
  end

endmodule

// File: rtl/core/key_bitmap_raster_generator.sv
// Top level of the key bitmap raster generator.
//
// Each word accepted on the item channel (valid/ready) either restarts the
// key at its first cell (action 0, no result) or produces the next cell of
// the key bitmap (action 1), column-major, one byte per cell. A cell that
// draws glyph data consumes glyph_byte and reports it in glyph_taken.
// Results leave on the result channel (valid/ready) after the classified-cell
// queue, the carry-store read stage and the result register. Throughput is
// one cell per cycle while the receiver is ready; the carry store takes one
// read and one write per cell, and the same row of neighboring columns is H
// cells apart (H at least four), so consecutive cells never wait on each other.
// Configuration writes on the cfg channel are always ready and take effect
// on the next cycle; write them only while no cell is in flight.
// Reset (synchronous, active high) restores the register defaults and the
// first cell, and empties the pipeline; the carry store holds no reset value.
// When the receiver stalls, the result register and the stage behind it hold
// and the queue fills; item_ready drops once the queue is full.
module key_bitmap_raster_generator import kbrg_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result
);

  cell_cmd_t front_cmd, queue_cmd;
  logic      front_valid, front_ready, queue_valid, queue_ready;

  assign cfg_ready = 1'b1;

  kbrg_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  kbrg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_cmd   (queue_cmd)
  );

  kbrg_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (queue_valid),
    .cmd_ready    (queue_ready),
    .cmd          (queue_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: verif/tb.sv
// Self-checking testbench for the key bitmap raster generator.
module tb;
  import kbrg_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CARRY_ROWS   = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  item_t                  item = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;

  key_bitmap_raster_generator dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  // Clock with a period of 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copy held by the predictor, starting at the reset defaults.
  logic [6:0] cfg_key_columns = 7'd8;
  logic [6:0] cfg_key_rows = 7'd16;
  logic       cfg_invert = 1'b0;
  logic       cfg_glyph_on = 1'b0;
  logic [6:0] cfg_glyph_columns = 7'd0;
  logic [6:0] cfg_glyph_rows = 7'd0;

  // Raster position and per-row nibble carry of the predictor.
  int         cur_row = 0;
  int         cur_col = 0;
  logic [3:0] nib_carry [CARRY_ROWS];

  item_t   words_to_send [$];
  result_t cells_due [$];
  result_t due;

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  int  send_gap = 0;
  int  ready_wait = 0;
  int  hold_cycles = 0;
  bit  item_done = 1'b0;
  bit  result_done = 1'b0;

  function automatic int clamp_dim(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 7));
  endfunction

  // Works out the cell that one accepted word produces, if any.
  function automatic void render_cell(item_t word);
    int         w, h, gx, gy, l, k, cx, cy, hl, hr, vu, vd;
    bit         at_line, at_end_row, at_left, at_right, odd, rows_in, taken;
    logic [7:0] fill, b, g;
    logic [3:0] carried;
    result_t    cell_out;
    w = clamp_dim(cfg_key_columns, 2, 64);
    h = clamp_dim(cfg_key_rows, 4, 64);
    gx = cfg_glyph_columns;
    gy = cfg_glyph_rows;
    g = word.glyph_byte;
    taken = 1'b0;
    if (!word.action) begin
      cur_row = 0;
      cur_col = 0;
      return;
    end
    if (cur_col >= w || cur_row >= h) begin
      cur_row = 0;
      cur_col = 0;
    end
    l = cur_col;
    k = cur_row;

    // Frame: lines on the second and second-to-last rows, sides, clear corners.
    at_line = (k == 1) || (k == h - 2);
    at_end_row = (k == 0) || (k == h - 1);
    at_left = (l == 0);
    at_right = (l == w - 1);
    if (at_line) fill = FRAME_LINE;
    else if (!at_left && !at_right) fill = FRAME_EMPTY;
    else fill = at_left ? FRAME_SIDE_L : FRAME_SIDE_R;
    if ((at_left || at_right) && at_end_row) fill = FRAME_EMPTY;
    if (at_line && at_left) fill = FRAME_LINE_L;
    if (at_line && at_right) fill = FRAME_LINE_R;
    b = fill;

    // Centered glyph; an odd leftover width shifts it by half a byte.
    if (cfg_glyph_on && gx <= w && gy <= h) begin
      cx = (w - gx) / 2;
      cy = (h - gy) / 2;
      hl = w - gx - cx;
      hr = w - cx;
      vu = h - gy - cy;
      vd = h - cy;
      odd = ((w - gx) % 2) != 0;
      rows_in = (k >= vu) && (k < vd);
      if (rows_in && l >= hl && l < hr) begin
        if (odd) begin
          carried = nib_carry[k];
          if (l + 1 < hr) begin
            b = {carried, 4'h0} | (fill ^ {4'h0, g[7:4]});
            nib_carry[k] = g[3:0];
            taken = 1'b1;
          end else begin
            b = {carried, 4'h0} | fill;
          end
        end else begin
          b = fill ^ g;
          taken = 1'b1;
        end
      end else if (odd && rows_in && l + 1 == hl && l + 1 < hr) begin
        nib_carry[k] = g[3:0];
        b = fill ^ {4'h0, g[7:4]};
        taken = 1'b1;
      end
    end
    if (cfg_invert) b = ~b;

    cell_out.cell_byte = b;
    cell_out.cell_row = k[5:0];
    cell_out.cell_column = l[5:0];
    cell_out.glyph_taken = taken;
    cell_out.last_cell = (l == w - 1) && (k == h - 1);
    cells_due.push_back(cell_out);

    // Column-major advance with wrap after the last cell.
    if (k + 1 >= h) begin
      cur_row = 0;
      cur_col = (l + 1 >= w) ? 0 : l + 1;
    end else begin
      cur_row = k + 1;
    end
  endfunction

  // Word driver: offers queued words at the falling edge, with random gaps.
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) begin
      render_cell(item);
      item_done = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_done) begin
      item_done = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        item <= words_to_send.pop_front();
        item_valid <= 1'b1;
        send_gap = draw_wait();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares each accepted cell with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      result_done = 1'b1;
      if (cells_due.size() == 0) begin
        mismatches++;
        $display("%0t: cell with nothing expected: byte %h row %0d col %0d",
                 $time, result.cell_byte, result.cell_row, result.cell_column);
      end else begin
        due = cells_due.pop_front();
        if (result.cell_byte !== due.cell_byte || result.cell_row !== due.cell_row ||
            result.cell_column !== due.cell_column ||
            result.glyph_taken !== due.glyph_taken ||
            result.last_cell !== due.last_cell) begin
          mismatches++;
          $display("%0t: expected byte %h row %0d col %0d taken %b last %b", $time,
                   due.cell_byte, due.cell_row, due.cell_column, due.glyph_taken,
                   due.last_cell);
          $display("%0t:   actual byte %h row %0d col %0d taken %b last %b", $time,
                   result.cell_byte, result.cell_row, result.cell_column,
                   result.glyph_taken, result.last_cell);
        end
      end
    end
  end

  // Receiver stalls: a random wait per cell, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_done) begin
        result_done = 1'b0;
        ready_wait = draw_wait();
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_ready <= 1'b0;
      end else if (ready_wait > 0) begin
        ready_wait--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_bitmap_raster_generator: mismatch");
      $finish;
    end
  end

  task automatic queue_word(input bit act, input logic [7:0] glyph);
    item_t word;
    word.action = act;
    word.glyph_byte = glyph;
    words_to_send.push_back(word);
  endtask

  // Waits until every word is taken and every cell has arrived, then lets
  // the pipeline drain words that produce no cell.
  task automatic wait_idle();
    do @(posedge clk);
    while (words_to_send.size() != 0 || item_valid || cells_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_KEY_COLUMNS:   cfg_key_columns = val;
      REG_KEY_ROWS:      cfg_key_rows = val;
      REG_INVERT_KEY:    cfg_invert = val[0];
      REG_GLYPH_PRESENT: cfg_glyph_on = val[0];
      REG_GLYPH_COLUMNS: cfg_glyph_columns = val;
      REG_GLYPH_ROWS:    cfg_glyph_rows = val;
      default: ;
    endcase
  endtask

  task automatic program_key(input int cols, input int rows, input bit inv,
                             input bit glyph_on, input int gcols, input int grows);
    write_reg(REG_KEY_COLUMNS, cols[6:0]);
    write_reg(REG_KEY_ROWS, rows[6:0]);
    write_reg(REG_INVERT_KEY, {6'd0, inv});
    write_reg(REG_GLYPH_PRESENT, {6'd0, glyph_on});
    write_reg(REG_GLYPH_COLUMNS, gcols[6:0]);
    write_reg(REG_GLYPH_ROWS, grows[6:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Key size: mostly small, sometimes the maximum or any 7-bit value.
  function automatic int pick_dim(int lo, int hi);
    case ($urandom_range(0, 11))
      0: return $urandom_range(0, 127);
      1: return 64;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Glyph size: mostly fits the key, sometimes oversized or any 7-bit value.
  function automatic int pick_glyph(int dim);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 127);
      1: return dim + 1;
      default: return $urandom_range(0, dim);
    endcase
  endfunction

  initial begin
    int  random_sent;
    int  phase;
    int  n;
    int  kc, kr, w, h;
    random_sent = 0;
    phase = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default key: a restart, then part of the first column.
    queue_word(1'b0, 8'h00);
    repeat (6) queue_word(1'b1, 8'hff);
    wait_idle();

    // Smallest key with a one-column glyph: the row counter now lies beyond
    // the key, so the block restarts by itself. Covers carry out, carry end
    // and the wrap after the last cell.
    program_key(2, 4, 1'b0, 1'b1, 1, 2);
    for (int i = 0; i < 9; i++) queue_word(1'b1, i[0] ? 8'h00 : 8'hff);
    wait_idle();

    // Glyph wider than the key is not drawn; inverted output.
    program_key(2, 4, 1'b1, 1'b1, 3, 2);
    queue_word(1'b0, 8'hff);
    repeat (4) queue_word(1'b1, 8'ha5);
    wait_idle();

    // Empty glyph takes no byte.
    program_key(2, 4, 1'b0, 1'b1, 0, 2);
    queue_word(1'b0, 8'h00);
    repeat (4) queue_word(1'b1, 8'h5a);

    // Random phases: whole keys with random glyph data, some restarts.
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      kc = pick_dim(2, 8);
      kr = pick_dim(4, 12);
      w = clamp_dim(kc, 2, 64);
      h = clamp_dim(kr, 4, 64);
      program_key(kc, kr, $urandom_range(0, 1), $urandom_range(0, 3) != 0,
                  pick_glyph(w), pick_glyph(h));
      // Restart whenever the position falls inside the new key, and at random
      // otherwise; a mid-key change must never read a carry row that was not written.
      if ((cur_col < w && cur_row < h) || $urandom_range(0, 1) == 0)
        queue_word(1'b0, $urandom_range(0, 255));
      if (phase == 2) begin
        quiet = 1'b1;
        hold_cycles = 250;
      end
      n = $urandom_range(30, 130);
      repeat (n) queue_word($urandom_range(0, 19) != 0, $urandom_range(0, 255));
      random_sent += n;
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("key_bitmap_raster_generator: match");
    end else begin
      $display("key_bitmap_raster_generator: mismatch");
    end
    $finish;
  end

endmodule
